// File: rtl/ffpa_pkg.sv
// Package for the first-fit partition allocator.
// Holds request and status codes, default sizes and the table control struct.
// No dependencies.
package ffpa_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned MaxEntriesDef = 32;
  localparam int unsigned UnitBitsDef   = 16;

  // Fixed field widths
  localparam int unsigned OwnerW  = 16;
  localparam int unsigned ReqW    = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 6;

  // Request types
  localparam logic [1:0] ReqAlloc   = 2'd0;
  localparam logic [1:0] ReqFree    = 2'd1;
  localparam logic [1:0] ReqCompact = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StNoFit    = 3'd1;
  localparam logic [StatusW-1:0] StNotFound = 3'd2;
  localparam logic [StatusW-1:0] StFull     = 3'd3;
  localparam logic [StatusW-1:0] StBadReq   = 3'd4;

  // Control from the sequencer and top level to the table
  typedef struct packed {
    logic we;      // write the entry at the write address
    logic reinit;  // table goes back to one free partition
  } tbl_ctl_t;

endpackage

// File: rtl/ffpa_table.sv
// Partition table memory with one write and one registered read port.
// Entry 0 reads as the full free partition until written after a reinit.
// Depends on ffpa_pkg.
module ffpa_table #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned UNIT_BITS   = 16,
  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned EntW = UNIT_BITS + 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ffpa_pkg::tbl_ctl_t ctl_i,
  input  logic [IdxW-1:0]    raddr_i,
  input  logic [IdxW-1:0]    waddr_i,
  input  logic [EntW-1:0]    wdata_i,
  input  logic [UNIT_BITS-1:0] total_i,
  output logic [EntW-1:0]    rdata_o
);
  import ffpa_pkg::*;

  logic [EntW-1:0] mem [MAX_ENTRIES];
  logic [EntW-1:0] rdata_q;
  logic            init_q;
  logic            ov_q;

  // Write, then read old data on an address collision
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // Track whether entry 0 still holds its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b1;
      ov_q   <= 1'b0;
    end else begin
      ov_q <= (raddr_i == '0) && init_q;
      if (ctl_i.reinit) begin
        init_q <= 1'b1;
      end else if (ctl_i.we && (waddr_i == '0)) begin
        init_q <= 1'b0;
      end
    end
  end

  assign rdata_o = ov_q ? {1'b0, total_i, {OwnerW{1'b0}}} : rdata_q;

endmodule

// File: rtl/ffpa_ctrl.sv
// Sequencer for allocate, free and compact over the partition table.
// One shared compare and add path walks the table one entry per cycle.
// Depends on ffpa_pkg.
module ffpa_ctrl #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned UNIT_BITS   = 16,
  localparam int unsigned IdxW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned LiveW = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned EntW  = UNIT_BITS + 17
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            reinit_i,
  input  logic                            start_i,
  input  logic [1:0]                      req_type_i,
  input  logic [ffpa_pkg::OwnerW-1:0]     owner_id_i,
  input  logic [ffpa_pkg::ReqW-1:0]       req_units_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [ffpa_pkg::StatusW-1:0]    status_o,
  output logic [15:0]                     base_offset_o,
  output logic [ffpa_pkg::CountW-1:0]     entry_count_o,
  output logic                            we_o,
  output logic [IdxW-1:0]                 raddr_o,
  output logic [IdxW-1:0]                 waddr_o,
  output logic [EntW-1:0]                 wdata_o,
  input  logic [EntW-1:0]                 rdata_i
);
  import ffpa_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SShift = 3'd2;
  localparam logic [2:0] SWrL   = 3'd3;
  localparam logic [2:0] SWrU   = 3'd4;
  localparam logic [2:0] SCSum  = 3'd5;
  localparam logic [2:0] SCMov  = 3'd6;
  localparam logic [2:0] SCFrnt = 3'd7;

  localparam logic [LiveW-1:0] LiveMax = LiveW'(MAX_ENTRIES);
  localparam logic [LiveW-1:0] LiveOne = LiveW'(1);

  logic [2:0]           state_q, state_d;
  logic [LiveW-1:0]     live_q, live_d;
  logic [LiveW-1:0]     idx_q, idx_d;
  logic [LiveW-1:0]     k_q, k_d;
  logic [LiveW-1:0]     hit_q, hit_d;
  logic [LiveW-1:0]     w_q, w_d;
  logic [LiveW-1:0]     used_q, used_d;
  logic [UNIT_BITS-1:0] off_q, off_d;
  logic [UNIT_BITS-1:0] left_q, left_d;
  logic [UNIT_BITS-1:0] fsum_q, fsum_d;
  logic                 front_q, front_d;
  logic                 alloc_q, alloc_d;
  logic [OwnerW-1:0]    owner_q, owner_d;
  logic [ReqW-1:0]      req_q, req_d;
  logic                 done_q, done_d;
  logic [StatusW-1:0]   status_q, status_d;
  logic [UNIT_BITS-1:0] base_q, base_d;

  logic [LiveW-1:0]     raddr_w;
  logic [LiveW-1:0]     waddr_w;

  // Entry fields and the shared compare / subtract / add path
  logic                    e_used;
  logic [UNIT_BITS-1:0]    e_units;
  logic [OwnerW-1:0]       e_owner;
  logic [UNIT_BITS+15:0]   units_x, req_x;
  logic [UNIT_BITS-1:0]    req_t;
  logic                    fits;
  logic [UNIT_BITS-1:0]    left_w;
  logic [UNIT_BITS-1:0]    sum_w;
  logic [UNIT_BITS-1:0]    sum_in;

  assign e_used  = rdata_i[EntW-1];
  assign e_units = rdata_i[UNIT_BITS+15:16];
  assign e_owner = rdata_i[15:0];
  assign units_x = {16'd0, e_units};
  assign req_x   = {{UNIT_BITS{1'b0}}, req_q};
  assign req_t   = req_x[UNIT_BITS-1:0];
  assign fits    = units_x >= req_x;
  assign left_w  = e_units - req_t;
  assign sum_in  = (state_q == SCSum) ? fsum_q : off_q;
  assign sum_w   = sum_in + e_units;

  // Sequence one request
  always_comb begin
    state_d  = state_q;
    live_d   = live_q;
    idx_d    = idx_q;
    k_d      = k_q;
    hit_d    = hit_q;
    w_d      = w_q;
    used_d   = used_q;
    off_d    = off_q;
    left_d   = left_q;
    fsum_d   = fsum_q;
    front_d  = front_q;
    alloc_d  = alloc_q;
    owner_d  = owner_q;
    req_d    = req_q;
    done_d   = 1'b0;
    status_d = status_q;
    base_d   = base_q;
    raddr_w  = idx_q;
    waddr_w  = idx_q;
    we_o     = 1'b0;
    wdata_o  = rdata_i;

    unique case (state_q)
      SIdle: begin
        raddr_w = '0;
        if (start_i) begin
          idx_d   = '0;
          off_d   = '0;
          fsum_d  = '0;
          used_d  = '0;
          owner_d = owner_id_i;
          req_d   = req_units_i;
          alloc_d = (req_type_i == ReqAlloc);
          base_d  = '0;
          priority if (req_type_i == ReqAlloc) begin
            if ((owner_id_i == '0) || (req_units_i == '0)) begin
              done_d   = 1'b1;
              status_d = StBadReq;
            end else begin
              state_d = SScan;
            end
          end else if (req_type_i == ReqFree) begin
            if (owner_id_i == '0) begin
              done_d   = 1'b1;
              status_d = StBadReq;
            end else begin
              state_d = SScan;
            end
          end else if (req_type_i == ReqCompact) begin
            state_d = SCSum;
          end else begin
            done_d   = 1'b1;
            status_d = StBadReq;
          end
        end
      end

      SScan: begin
        raddr_w = idx_q + LiveOne;
        if (idx_q == live_q) begin
          state_d  = SIdle;
          done_d   = 1'b1;
          status_d = alloc_q ? StNoFit : StNotFound;
        end else if (alloc_q && !e_used && fits) begin
          if ((left_w != '0) && (live_q == LiveMax)) begin
            state_d  = SIdle;
            done_d   = 1'b1;
            status_d = StFull;
          end else if (left_w == '0) begin
            we_o     = 1'b1;
            waddr_w  = idx_q;
            wdata_o  = {1'b1, req_t, owner_q};
            state_d  = SIdle;
            done_d   = 1'b1;
            status_d = StOk;
            base_d   = off_q;
          end else begin
            hit_d  = idx_q;
            left_d = left_w;
            if (live_q > (idx_q + LiveOne)) begin
              k_d     = live_q;
              raddr_w = live_q - LiveOne;
              state_d = SShift;
            end else begin
              state_d = SWrL;
            end
          end
        end else if (!alloc_q && e_used && (e_owner == owner_q)) begin
          we_o     = 1'b1;
          waddr_w  = idx_q;
          wdata_o  = {1'b0, e_units, {OwnerW{1'b0}}};
          state_d  = SIdle;
          done_d   = 1'b1;
          status_d = StOk;
          base_d   = off_q;
        end else begin
          off_d = sum_w;
          idx_d = idx_q + LiveOne;
        end
      end

      // Move entries up by one, from the top down
      SShift: begin
        we_o    = 1'b1;
        waddr_w = k_q;
        wdata_o = rdata_i;
        raddr_w = k_q - LiveW'(2);
        if (k_q == (hit_q + LiveW'(2))) begin
          state_d = SWrL;
        end else begin
          k_d = k_q - LiveOne;
        end
      end

      SWrL: begin
        we_o    = 1'b1;
        waddr_w = hit_q + LiveOne;
        wdata_o = {1'b0, left_q, {OwnerW{1'b0}}};
        state_d = SWrU;
      end

      SWrU: begin
        we_o     = 1'b1;
        waddr_w  = hit_q;
        wdata_o  = {1'b1, req_t, owner_q};
        live_d   = live_q + LiveOne;
        state_d  = SIdle;
        done_d   = 1'b1;
        status_d = StOk;
        base_d   = off_q;
      end

      // First compact pass: total free space and count used entries
      SCSum: begin
        raddr_w = idx_q + LiveOne;
        if (idx_q == live_q) begin
          front_d = (fsum_q != '0) || (used_q == '0);
          w_d     = ((fsum_q != '0) || (used_q == '0)) ? LiveOne : '0;
          idx_d   = '0;
          raddr_w = '0;
          state_d = SCMov;
        end else begin
          if (e_used) begin
            used_d = used_q + LiveOne;
          end else begin
            fsum_d = sum_w;
          end
          idx_d = idx_q + LiveOne;
        end
      end

      // Second pass: pack used entries; write never passes the next read
      SCMov: begin
        raddr_w = idx_q + LiveOne;
        if (idx_q == live_q) begin
          live_d = w_q;
          if (front_q) begin
            state_d = SCFrnt;
          end else begin
            state_d  = SIdle;
            done_d   = 1'b1;
            status_d = StOk;
          end
        end else begin
          if (e_used) begin
            we_o    = 1'b1;
            waddr_w = w_q;
            wdata_o = rdata_i;
            w_d     = w_q + LiveOne;
          end
          idx_d = idx_q + LiveOne;
        end
      end

      SCFrnt: begin
        we_o     = 1'b1;
        waddr_w  = '0;
        wdata_o  = {1'b0, fsum_q, {OwnerW{1'b0}}};
        state_d  = SIdle;
        done_d   = 1'b1;
        status_d = StOk;
      end

      default: begin
        state_d = SIdle;
      end
    endcase

    if (reinit_i) begin
      live_d = LiveOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      live_q  <= LiveOne;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    k_q      <= k_d;
    hit_q    <= hit_d;
    w_q      <= w_d;
    used_q   <= used_d;
    off_q    <= off_d;
    left_q   <= left_d;
    fsum_q   <= fsum_d;
    front_q  <= front_d;
    alloc_q  <= alloc_d;
    owner_q  <= owner_d;
    req_q    <= req_d;
    status_q <= status_d;
    base_q   <= base_d;
  end

  // Drive result ports
  logic [LiveW+5:0]      live_x;
  logic [UNIT_BITS+15:0] base_x;
  assign live_x        = {6'd0, live_q};
  assign base_x        = {16'd0, base_q};
  assign entry_count_o = live_x[5:0];
  assign base_offset_o = base_x[15:0];
  assign status_o      = status_q;
  assign done_o        = done_q;
  assign busy_o        = (state_q != SIdle);
  assign raddr_o       = raddr_w[IdxW-1:0];
  assign waddr_o       = waddr_w[IdxW-1:0];

endmodule

// File: rtl/first_fit_partition_allocator.sv
// First-fit variable partition allocator, top level.
// Depends on ffpa_pkg, ffpa_table and ffpa_ctrl.
//
//  channel   ports                                        handshake
//  request   req_type_i owner_id_i req_units_i            start_i & !busy_o
//  result    status_o base_offset_o entry_count_o         done_o, one cycle
//  config    total_units_i                                total_units_we_i
//
// The sequencer walks the table one entry per cycle through one read port.
// An allocate with a split moves the entries above the hit up one a cycle.
// A miss walks every live entry. Compact takes two passes, and writes one
// more entry when a free front partition is left.
// Bad requests are answered from idle, without a table walk.
// Reset leaves one free partition of 16'hFFFF units masked to UNIT_BITS;
// no clearing pass is needed.
// The receiver cannot stall: each result word is shown for one cycle.
module first_fit_partition_allocator #(
  parameter int unsigned MAX_ENTRIES = ffpa_pkg::MaxEntriesDef,
  parameter int unsigned UNIT_BITS   = ffpa_pkg::UnitBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          total_units_we_i,
  input  logic [15:0]                   total_units_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    req_type_i,
  input  logic [ffpa_pkg::OwnerW-1:0]   owner_id_i,
  input  logic [ffpa_pkg::ReqW-1:0]     req_units_i,
  output logic                          done_o,
  output logic [ffpa_pkg::StatusW-1:0]  status_o,
  output logic [15:0]                   base_offset_o,
  output logic [ffpa_pkg::CountW-1:0]   entry_count_o
);
  import ffpa_pkg::*;

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EntW = UNIT_BITS + 17;

  logic [UNIT_BITS+15:0] tot_x, tot_rst_x;
  logic [UNIT_BITS-1:0]  total_q;
  tbl_ctl_t              ctl;
  logic                  we;
  logic [IdxW-1:0]       raddr, waddr;
  logic [EntW-1:0]       wdata, rdata;
  logic                  start_acc;

  assign tot_x     = {{UNIT_BITS{1'b0}}, total_units_i};
  assign tot_rst_x = {{UNIT_BITS{1'b0}}, 16'hFFFF};

  // Hold the configured size, masked to the unit width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= tot_rst_x[UNIT_BITS-1:0];
    end else if (total_units_we_i) begin
      total_q <= tot_x[UNIT_BITS-1:0];
    end
  end

  assign start_acc  = start_i && !busy_o;
  assign ctl.we     = we;
  assign ctl.reinit = total_units_we_i;

  ffpa_table #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .UNIT_BITS  (UNIT_BITS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .raddr_i(raddr),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .total_i(total_q),
    .rdata_o(rdata)
  );

  ffpa_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .UNIT_BITS  (UNIT_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reinit_i     (total_units_we_i),
    .start_i      (start_acc),
    .req_type_i   (req_type_i),
    .owner_id_i   (owner_id_i),
    .req_units_i  (req_units_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .status_o     (status_o),
    .base_offset_o(base_offset_o),
    .entry_count_o(entry_count_o),
    .we_o         (we),
    .raddr_o      (raddr),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .rdata_i      (rdata)
  );

endmodule

// File: bench/tb_first_fit_partition_allocator.sv
// Testbench for the first-fit partition allocator: directed and random requests,
// checked word by word against a behavioral table model kept in the bench.
// Depends on ffpa_pkg and first_fit_partition_allocator.
module tb_first_fit_partition_allocator;
  import ffpa_pkg::*;

  localparam int unsigned Slots = 32;
  localparam logic [1:0]  ReqNone = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] owner;
    logic [15:0] units;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] base;
    logic [5:0]  count;
  } rsp_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        total_units_we_i = 1'b0;
  logic [15:0] total_units_i = '0;
  logic        start_i = 1'b0;
  logic [1:0]  req_type_i = '0;
  logic [15:0] owner_id_i = '0;
  logic [15:0] req_units_i = '0;
  logic        busy_o, done_o;
  logic [2:0]  status_o;
  logic [15:0] base_offset_o;
  logic [5:0]  entry_count_o;

  first_fit_partition_allocator dut (
    .clk_i, .rst_ni, .total_units_we_i, .total_units_i, .start_i, .busy_o,
    .req_type_i, .owner_id_i, .req_units_i, .done_o, .status_o,
    .base_offset_o, .entry_count_o
  );

  // Shadow partition table
  logic        part_used [Slots];
  logic [15:0] part_units[Slots];
  logic [15:0] part_owner[Slots];
  int unsigned part_live;

  req_word_t   pending_reqs[$];
  rsp_word_t   expected_rsps[$];
  int unsigned fail_count = 0;
  bit          quiet = 1'b0;
  bit          cfg_pending = 1'b0;
  logic [15:0] cfg_value;

  function automatic void table_reinit(input logic [15:0] total);
    for (int i = 0; i < Slots; i++) begin
      part_used[i] = 1'b0; part_units[i] = '0; part_owner[i] = '0;
    end
    part_units[0] = total;
    part_live = 1;
  endfunction

  function automatic logic [15:0] offset_at(input int unsigned idx);
    logic [15:0] sum;
    sum = '0;
    for (int i = 0; i < idx; i++) sum += part_units[i];
    return sum;
  endfunction

  // Apply one request to the shadow table and return the word it should give
  function automatic rsp_word_t apply_request(input req_word_t r);
    rsp_word_t   w;
    int unsigned hit;
    logic [15:0] left, free_sum;
    logic        nu[Slots];
    logic [15:0] nz[Slots], no[Slots];
    int unsigned n, used;
    w = '0;
    hit = part_live;
    case (r.kind)
      ReqAlloc: begin
        if (r.owner == 0 || r.units == 0) w.status = StBadReq;
        else begin
          for (int i = part_live - 1; i >= 0; i--)
            if (!part_used[i] && part_units[i] >= r.units) hit = i;
          if (hit == part_live) w.status = StNoFit;
          else begin
            left = part_units[hit] - r.units;
            if (left != 0 && part_live >= Slots) w.status = StFull;
            else begin
              if (left != 0) begin
                for (int k = part_live; k > hit + 1; k--) begin
                  part_used[k] = part_used[k-1];
                  part_units[k] = part_units[k-1];
                  part_owner[k] = part_owner[k-1];
                end
                part_used[hit+1] = 1'b0; part_units[hit+1] = left;
                part_owner[hit+1] = '0;
                part_live++;
              end
              part_used[hit] = 1'b1; part_units[hit] = r.units;
              part_owner[hit] = r.owner;
              w.status = StOk; w.base = offset_at(hit);
            end
          end
        end
      end
      ReqFree: begin
        if (r.owner == 0) w.status = StBadReq;
        else begin
          for (int i = part_live - 1; i >= 0; i--)
            if (part_used[i] && part_owner[i] == r.owner) hit = i;
          if (hit == part_live) w.status = StNotFound;
          else begin
            part_used[hit] = 1'b0; part_owner[hit] = '0;
            w.status = StOk; w.base = offset_at(hit);
          end
        end
      end
      ReqCompact: begin
        free_sum = '0; used = 0;
        for (int i = 0; i < part_live; i++)
          if (part_used[i]) used++; else free_sum += part_units[i];
        for (int i = 0; i < Slots; i++) begin
          nu[i] = 1'b0; nz[i] = '0; no[i] = '0;
        end
        n = 0;
        if (free_sum != 0 || used == 0) begin
          nz[0] = free_sum; n = 1;
        end
        for (int i = 0; i < part_live; i++)
          if (part_used[i]) begin
            nu[n] = 1'b1; nz[n] = part_units[i]; no[n] = part_owner[i]; n++;
          end
        for (int i = 0; i < Slots; i++) begin
          part_used[i] = nu[i]; part_units[i] = nz[i]; part_owner[i] = no[i];
        end
        part_live = n;
        w.status = StOk;
      end
      default: w.status = StBadReq;
    endcase
    w.count = part_live[5:0];
    return w;
  endfunction

  function automatic req_word_t mk(input logic [1:0] k, input logic [15:0] o,
                                   input logic [15:0] u);
    req_word_t r;
    r.kind = k; r.owner = o; r.units = u;
    return r;
  endfunction

  // Random request: mostly small allocs and frees from a small owner pool
  function automatic req_word_t rand_request();
    int unsigned pick;
    logic [15:0] o, u;
    pick = $urandom_range(99);
    o = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(12));
    if ($urandom_range(9) == 0) u = 16'($urandom);
    else u = 16'($urandom_range(40));
    if (pick < 50) return mk(ReqAlloc, o, u);
    if (pick < 85) return mk(ReqFree, o, u);
    if (pick < 95) return mk(ReqCompact, 16'($urandom), 16'($urandom));
    return mk(ReqNone, 16'($urandom), 16'($urandom));
  endfunction

  initial forever #5 clk_i = ~clk_i;

  // Driver: present the next word, idling at random outside quiet stretches
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        void'(pending_reqs.pop_front());
      end
      if (cfg_pending && !start_i) begin
        total_units_we_i <= 1'b1;
        total_units_i <= cfg_value;
        cfg_pending = 1'b0;
      end else begin
        if (total_units_we_i) total_units_we_i <= 1'b0;
        if (start_i && busy_o) begin
          // hold the word until taken
        end else if (pending_reqs.size() != 0 && !cfg_pending &&
                     (quiet || $urandom_range(99) >= 8)) begin
          start_i <= 1'b1;
          req_type_i <= pending_reqs[0].kind;
          owner_id_i <= pending_reqs[0].owner;
          req_units_i <= pending_reqs[0].units;
          expected_rsps.push_back(apply_request(pending_reqs[0]));
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected word st=%0d base=%0d cnt=%0d", $time,
                 status_o, base_offset_o, entry_count_o);
        fail_count++;
      end else begin
        if (status_o !== expected_rsps[0].status ||
            base_offset_o !== expected_rsps[0].base ||
            entry_count_o !== expected_rsps[0].count) begin
          $display("%0t: expected st=%0d base=%0d cnt=%0d got st=%0d base=%0d cnt=%0d",
                   $time, expected_rsps[0].status, expected_rsps[0].base,
                   expected_rsps[0].count, status_o, base_offset_o, entry_count_o);
          fail_count++;
        end
        void'(expected_rsps.pop_front());
      end
    end
  end

  // Wait until every queued word is sent and answered, then let the block settle
  task automatic drain();
    while (pending_reqs.size() != 0 || start_i || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [15:0] v);
    cfg_value = v;
    cfg_pending = 1'b1;
    while (cfg_pending || total_units_we_i) @(posedge clk_i);
    @(posedge clk_i);
    table_reinit(v);
  endtask

  // Stimulus phases
  initial begin
    logic [15:0] sizes[4];
    table_reinit(16'hFFFF);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad requests, fits, splits, frees, compacts
    pending_reqs.push_back(mk(ReqNone, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(mk(ReqAlloc, 0, 5));
    pending_reqs.push_back(mk(ReqAlloc, 1, 0));
    pending_reqs.push_back(mk(ReqFree, 0, 0));
    pending_reqs.push_back(mk(ReqFree, 7, 0));
    pending_reqs.push_back(mk(ReqAlloc, 16'hFFFF, 100));
    pending_reqs.push_back(mk(ReqAlloc, 2, 16'hFFFF));
    pending_reqs.push_back(mk(ReqAlloc, 3, 200));
    pending_reqs.push_back(mk(ReqFree, 16'hFFFF, 0));
    pending_reqs.push_back(mk(ReqAlloc, 4, 100));
    pending_reqs.push_back(mk(ReqFree, 3, 0));
    pending_reqs.push_back(mk(ReqCompact, 0, 0));
    pending_reqs.push_back(mk(ReqAlloc, 5, 16'hFFFF - 300));
    pending_reqs.push_back(mk(ReqCompact, 0, 0));
    drain();

    // Zero total: everything misses, compact keeps one empty partition
    write_total(16'd0);
    pending_reqs.push_back(mk(ReqAlloc, 1, 1));
    pending_reqs.push_back(mk(ReqCompact, 0, 0));
    pending_reqs.push_back(mk(ReqAlloc, 1, 1));
    drain();

    // Table full: 31 unit splits, then a split is refused but an exact fit is not
    write_total(16'd40);
    for (int i = 1; i <= 31; i++) pending_reqs.push_back(mk(ReqAlloc, i, 1));
    pending_reqs.push_back(mk(ReqAlloc, 50, 2));
    pending_reqs.push_back(mk(ReqAlloc, 50, 9));
    pending_reqs.push_back(mk(ReqFree, 5, 0));
    pending_reqs.push_back(mk(ReqCompact, 0, 0));
    drain();

    // Random phases across several totals
    sizes = '{16'd1, 16'd120, 16'd400, 16'hFFFF};
    for (int ph = 0; ph < 4; ph++) begin
      write_total(sizes[ph]);
      quiet = (ph == 2);
      for (int i = 0; i < 220; i++) pending_reqs.push_back(rand_request());
      drain();
    end

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
